// File: hdl/tick_signal_order_engine_macros.svh
// Assertion macros for the tick signal order engine checker.
// Included by the checker module; no other dependencies.
`ifndef TICK_SIGNAL_ORDER_ENGINE_MACROS_SVH
`define TICK_SIGNAL_ORDER_ENGINE_MACROS_SVH

// same-cycle implication
`define TSOE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsoe assertion failed");

// next-cycle implication
`define TSOE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsoe assertion failed");

`endif

// File: hdl/tsoe_pkg.sv
// Shared types and constants for the tick signal order engine.
// No dependencies.
`timescale 1ns / 1ps

package tsoe_pkg;

  localparam int PRICE_BITS = 20;
  localparam int INST_W     = 4;
  localparam int INST_CNT   = 16;
  localparam int CNT_W      = 32;
  localparam int OFFS_W     = 10;
  localparam int BAND_W     = 7;
  localparam int MINH_W     = 5;

  localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;
  localparam logic [CNT_W-1:0]      CNT_MAX   = '1;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [PRICE_BITS-1:0] LOW_RST  = 20'd10500;
  localparam logic [PRICE_BITS-1:0] HIGH_RST = 20'd19500;
  localparam logic [BAND_W-1:0]     BAND_RST = 7'd2;
  localparam logic [MINH_W-1:0]     MINH_RST = 5'd5;
  localparam logic [OFFS_W-1:0]     OFFS_RST = 10'd1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 128;

  // shared multiplier operand widths
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 8;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [MUL_B_W-1:0] PCT_SCALE = 8'd100;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_RD_P2,
    ST_RD_P3,
    ST_UPDATE,
    ST_MUL_PN,
    ST_MUL_LHS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    REG_LOW  = 3'd0,
    REG_HIGH = 3'd1,
    REG_BAND = 3'd2,
    REG_MINH = 3'd3,
    REG_OFFS = 3'd4
  } cfg_reg_t;

endpackage

// File: hdl/tsoe_mul.sv
// Shared registered multiplier for the tick signal order engine.
// Depends on tsoe_pkg.
`timescale 1ns / 1ps

module tsoe_mul (
  input  logic                      clk,
  input  tsoe_pkg::mul_req_t        req,
  output logic [tsoe_pkg::MUL_P_W-1:0] prod
);

  logic [tsoe_pkg::MUL_P_W-1:0] prod_r;
  logic [tsoe_pkg::MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = tsoe_pkg::MUL_P_W'(req.a) * tsoe_pkg::MUL_P_W'(req.b);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

// File: hdl/tick_signal_order_engine.sv
// Tick signal order engine top level: window store, sequencer, config regs.
// Depends on tsoe_pkg and tsoe_mul.
`timescale 1ns / 1ps

// One tick request in, one order result out. A tick is taken only while the
// sequencer is idle and then passes through these steps to the result
// register: three reads of the price window memory through its single read
// port, an update step that writes the new price and the per-instrument
// count, head and running sum, four products through one shared multiplier,
// and a final step that evaluates the signals. The sequencer is idle again in
// the cycle after the result loads, so no new tick is taken before the last
// tick's result has loaded. A stalled result holds the tick in its final step,
// holding off the next tick. Config writes complete in the APB access cycle.

module tick_signal_order_engine #(
  parameter int NUM_INSTRUMENTS = 16,
  parameter int WINDOW          = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [3:0] instrument, [23:4] tick_price
  input  logic [tsoe_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] order_valid, [1] is_buy, [5:2] order_instrument, [25:6] order_price,
  // [57:26] signal_one_count, [89:58] signal_two_count,
  // [121:90] signal_three_count, [127:122] zero
  output logic [tsoe_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tsoe_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [tsoe_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [tsoe_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int PW     = tsoe_pkg::PRICE_BITS;
  localparam int HW     = $clog2(WINDOW);
  localparam int FW     = $clog2(WINDOW + 1);
  localparam int SUM_W  = PW + FW;
  localparam int NSLOT  = (NUM_INSTRUMENTS < tsoe_pkg::INST_CNT) ? NUM_INSTRUMENTS
                                                                  : tsoe_pkg::INST_CNT;
  localparam int SW     = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int MEM_D  = 2 ** (SW + HW);
  localparam int CW     = tsoe_pkg::CNT_W;

  // instrument field -> window slot
  function automatic logic [tsoe_pkg::INST_CNT*SW-1:0] inst_map_f();
    logic [tsoe_pkg::INST_CNT*SW-1:0] m;
    m = '0;
    for (int i = 0; i < tsoe_pkg::INST_CNT; i++) begin
      m[i*SW +: SW] = SW'(i % NUM_INSTRUMENTS);
    end
    return m;
  endfunction

  localparam logic [tsoe_pkg::INST_CNT*SW-1:0] INST_MAP = inst_map_f();

  // config registers
  logic [PW-1:0]                   low_r, high_r;
  logic [tsoe_pkg::BAND_W-1:0]     band_r;
  logic [tsoe_pkg::MINH_W-1:0]     minh_r;
  logic [tsoe_pkg::OFFS_W-1:0]     offs_r;
  logic                            cfg_wr;
  tsoe_pkg::cfg_reg_t              cfg_sel;

  // sequencer
  tsoe_pkg::state_t                state_r, state_nxt;

  // per-instrument window state
  logic [FW-1:0]                   fill_r [NSLOT];
  logic [HW-1:0]                   head_r [NSLOT];
  logic [SUM_W-1:0]                sum_r  [NSLOT];

  logic [PW-1:0]                   mem [MEM_D];
  logic [PW-1:0]                   rd_data_r;
  logic [SW+HW-1:0]                rd_addr;
  logic                            mem_we;

  // item registers
  logic [tsoe_pkg::INST_W-1:0]     inst_r;
  logic [SW-1:0]                   slot_r;
  logic [PW-1:0]                   price_r;
  logic [PW-1:0]                   old_r, p2_r, p3_r;
  logic [FW-1:0]                   n_r;
  logic [SUM_W-1:0]                nsum_r;
  logic [SUM_W-1:0]                pn_r;
  logic [tsoe_pkg::MUL_P_W-1:0]    lhs_r, rlo_r;

  logic [CW-1:0]                   cnt1_r, cnt2_r, cnt3_r;
  logic                            out_valid_r;
  logic [tsoe_pkg::OUT_DATA_W-1:0] out_data_r;

  tsoe_pkg::mul_req_t              mul_req;
  logic [tsoe_pkg::MUL_P_W-1:0]    prod;

  logic [HW-1:0]                   h, h_m1, h_m2, h_inc;
  logic                            full;
  logic [FW-1:0]                   fill_new;
  logic [SUM_W-1:0]                sum_new;
  logic                            out_free, fin_load;

  logic                            s1, s2, s3, hist_ok, below, above, under_avg;
  logic                            buy, sell;
  logic [PW:0]                     price_up;
  logic [PW-1:0]                   ord_price;

  // ---------------- config port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_sel    = tsoe_pkg::cfg_reg_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= tsoe_pkg::LOW_RST;
      high_r <= tsoe_pkg::HIGH_RST;
      band_r <= tsoe_pkg::BAND_RST;
      minh_r <= tsoe_pkg::MINH_RST;
      offs_r <= tsoe_pkg::OFFS_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        tsoe_pkg::REG_LOW:  low_r  <= cfg_pwdata[PW-1:0];
        tsoe_pkg::REG_HIGH: high_r <= cfg_pwdata[PW-1:0];
        tsoe_pkg::REG_BAND: band_r <= cfg_pwdata[tsoe_pkg::BAND_W-1:0];
        tsoe_pkg::REG_MINH: minh_r <= cfg_pwdata[tsoe_pkg::MINH_W-1:0];
        tsoe_pkg::REG_OFFS: offs_r <= cfg_pwdata[tsoe_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      tsoe_pkg::REG_LOW:  cfg_prdata = tsoe_pkg::CFG_DW'(low_r);
      tsoe_pkg::REG_HIGH: cfg_prdata = tsoe_pkg::CFG_DW'(high_r);
      tsoe_pkg::REG_BAND: cfg_prdata = tsoe_pkg::CFG_DW'(band_r);
      tsoe_pkg::REG_MINH: cfg_prdata = tsoe_pkg::CFG_DW'(minh_r);
      tsoe_pkg::REG_OFFS: cfg_prdata = tsoe_pkg::CFG_DW'(offs_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // ---------------- window pointers ----------------
  assign h     = head_r[slot_r];
  assign h_m1  = (h >= HW'(1)) ? h - HW'(1) : h + HW'(WINDOW - 1);
  assign h_m2  = (h >= HW'(2)) ? h - HW'(2) : h + HW'(WINDOW - 2);
  assign h_inc = (h == HW'(WINDOW - 1)) ? '0 : h + HW'(1);
  assign full  = (fill_r[slot_r] >= FW'(WINDOW));
  assign fill_new = full ? fill_r[slot_r] : fill_r[slot_r] + FW'(1);
  assign sum_new  = sum_r[slot_r] - (full ? SUM_W'(old_r) : '0) + SUM_W'(price_r);

  assign out_free = !out_valid_r || out_tready;
  assign fin_load = (state_r == tsoe_pkg::ST_FINISH) && out_free;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsoe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsoe_pkg::ST_IDLE:    if (in_tvalid) state_nxt = tsoe_pkg::ST_RD_OLD;
      tsoe_pkg::ST_RD_OLD:  state_nxt = tsoe_pkg::ST_RD_P2;
      tsoe_pkg::ST_RD_P2:   state_nxt = tsoe_pkg::ST_RD_P3;
      tsoe_pkg::ST_RD_P3:   state_nxt = tsoe_pkg::ST_UPDATE;
      tsoe_pkg::ST_UPDATE:  state_nxt = tsoe_pkg::ST_MUL_PN;
      tsoe_pkg::ST_MUL_PN:  state_nxt = tsoe_pkg::ST_MUL_LHS;
      tsoe_pkg::ST_MUL_LHS: state_nxt = tsoe_pkg::ST_MUL_LO;
      tsoe_pkg::ST_MUL_LO:  state_nxt = tsoe_pkg::ST_MUL_HI;
      tsoe_pkg::ST_MUL_HI:  state_nxt = tsoe_pkg::ST_FINISH;
      tsoe_pkg::ST_FINISH:  if (out_free) state_nxt = tsoe_pkg::ST_IDLE;
      default:              state_nxt = tsoe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = {slot_r, h};
    mul_req   = '0;
    case (state_r)
      tsoe_pkg::ST_IDLE:    in_tready = 1'b1;
      tsoe_pkg::ST_RD_OLD:  rd_addr = {slot_r, h};
      tsoe_pkg::ST_RD_P2:   rd_addr = {slot_r, h_m1};
      tsoe_pkg::ST_RD_P3:   rd_addr = {slot_r, h_m2};
      tsoe_pkg::ST_UPDATE:  mem_we = 1'b1;
      tsoe_pkg::ST_MUL_PN: begin
        mul_req.en = 1'b1;
        mul_req.a  = tsoe_pkg::MUL_A_W'(price_r);
        mul_req.b  = tsoe_pkg::MUL_B_W'(n_r);
      end
      tsoe_pkg::ST_MUL_LHS: begin
        mul_req.en = 1'b1;
        mul_req.a  = prod[tsoe_pkg::MUL_A_W-1:0];
        mul_req.b  = tsoe_pkg::PCT_SCALE;
      end
      tsoe_pkg::ST_MUL_LO: begin
        mul_req.en = 1'b1;
        mul_req.a  = tsoe_pkg::MUL_A_W'(nsum_r);
        mul_req.b  = tsoe_pkg::PCT_SCALE - tsoe_pkg::MUL_B_W'(band_r);
      end
      tsoe_pkg::ST_MUL_HI: begin
        mul_req.en = 1'b1;
        mul_req.a  = tsoe_pkg::MUL_A_W'(nsum_r);
        mul_req.b  = tsoe_pkg::PCT_SCALE + tsoe_pkg::MUL_B_W'(band_r);
      end
      default: ;
    endcase
  end

  tsoe_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // ---------------- price window memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{slot_r, h}] <= price_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // ---------------- per-instrument state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
        sum_r[i]  <= '0;
      end
    end else if (state_r == tsoe_pkg::ST_UPDATE) begin
      fill_r[slot_r] <= fill_new;
      head_r[slot_r] <= h_inc;
      sum_r[slot_r]  <= sum_new;
    end
  end

  // ---------------- item datapath ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      tsoe_pkg::ST_IDLE: begin
        inst_r  <= in_tdata[tsoe_pkg::INST_W-1:0];
        slot_r  <= INST_MAP[in_tdata[tsoe_pkg::INST_W-1:0]*SW +: SW];
        price_r <= in_tdata[tsoe_pkg::INST_W +: PW];
      end
      tsoe_pkg::ST_RD_P2:   old_r <= rd_data_r;
      tsoe_pkg::ST_RD_P3:   p2_r  <= rd_data_r;
      tsoe_pkg::ST_UPDATE: begin
        p3_r   <= rd_data_r;
        n_r    <= fill_new;
        nsum_r <= sum_new;
      end
      tsoe_pkg::ST_MUL_LHS: pn_r  <= prod[SUM_W-1:0];
      tsoe_pkg::ST_MUL_LO:  lhs_r <= prod;
      tsoe_pkg::ST_MUL_HI:  rlo_r <= prod;
      default: ;
    endcase
  end

  // ---------------- signal evaluation ----------------
  always_comb begin
    s1        = (price_r < low_r) || (price_r > high_r);
    hist_ok   = (tsoe_pkg::MINH_W'(n_r) >= minh_r);
    below     = (band_r < tsoe_pkg::BAND_W'(tsoe_pkg::PCT_SCALE)) && (lhs_r < rlo_r);
    above     = (lhs_r > prod);
    s2        = hist_ok && (below || above);
    s3        = (n_r >= FW'(3)) && (p3_r < p2_r) && (p2_r < price_r);
    under_avg = (pn_r < nsum_r);
    buy       = s1 || (s2 && under_avg) || s3;
    sell      = s2 && !under_avg && !buy;
    price_up  = {1'b0, price_r} + (PW + 1)'(offs_r);
    if (buy) begin
      ord_price = price_up[PW] ? tsoe_pkg::PRICE_MAX : price_up[PW-1:0];
    end else if (sell) begin
      ord_price = (price_r > PW'(offs_r)) ? price_r - PW'(offs_r) : '0;
    end else begin
      ord_price = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt1_r <= '0;
      cnt2_r <= '0;
      cnt3_r <= '0;
    end else if (fin_load) begin
      if (s1 && cnt1_r != tsoe_pkg::CNT_MAX) cnt1_r <= cnt1_r + CW'(1);
      if (s2 && cnt2_r != tsoe_pkg::CNT_MAX) cnt2_r <= cnt2_r + CW'(1);
      if (s3 && cnt3_r != tsoe_pkg::CNT_MAX) cnt3_r <= cnt3_r + CW'(1);
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_data_r <= {6'b0,
                     (s3 && cnt3_r != tsoe_pkg::CNT_MAX) ? cnt3_r + CW'(1) : cnt3_r,
                     (s2 && cnt2_r != tsoe_pkg::CNT_MAX) ? cnt2_r + CW'(1) : cnt2_r,
                     (s1 && cnt1_r != tsoe_pkg::CNT_MAX) ? cnt1_r + CW'(1) : cnt1_r,
                     ord_price, inst_r, buy, buy || sell};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hdl/tsoe_chk.sv
// Port-level checker for the tick signal order engine, bound to the top level.
// Depends on tick_signal_order_engine_macros.svh and tsoe_pkg.
`timescale 1ns / 1ps
`include "tick_signal_order_engine_macros.svh"

module tsoe_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tsoe_pkg::OUT_DATA_W-1:0] out_tdata
);

  `TSOE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `TSOE_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `TSOE_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_tvalid && in_tready, !$rose(out_tvalid))
  `TSOE_ASSERT_NOW(a_no_order_clean, clk, rst_n, out_tvalid && !out_tdata[0], !out_tdata[1] && out_tdata[25:6] == 20'd0)

endmodule

bind tick_signal_order_engine tsoe_chk u_tsoe_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/tick_signal_order_engine_test.sv
// Self-checking testbench for tick_signal_order_engine: ticks in, orders out.
// Predicts every order and checks it field by field; depends on tsoe_pkg.
`timescale 1ns / 1ps

module tick_signal_order_engine_test;

  localparam int WINDOW          = 10;
  localparam int FIRST_SPARE_REG = 5;
  localparam int LAST_REG_SLOT   = (1 << tsoe_pkg::CFG_AW) / 4 - 1;
  localparam int QUIET_LIMIT     = 2000;
  localparam int PHASES          = 8;
  localparam int PHASE_TICKS     = 150;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [5:0]                      spare;
    logic [tsoe_pkg::CNT_W-1:0]      rise_hits;
    logic [tsoe_pkg::CNT_W-1:0]      dev_hits;
    logic [tsoe_pkg::CNT_W-1:0]      band_hits;
    logic [tsoe_pkg::PRICE_BITS-1:0] order_price;
    logic [tsoe_pkg::INST_W-1:0]     order_instrument;
    logic                            is_buy;
    logic                            order_valid;
  } order_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [tsoe_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tsoe_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [tsoe_pkg::CFG_AW-1:0]     cfg_paddr = '0;
  logic [tsoe_pkg::CFG_DW-1:0]     cfg_pwdata = '0;
  logic [tsoe_pkg::CFG_DW-1:0]     cfg_prdata;
  logic                            cfg_pready;

  // engine state as predicted
  logic [tsoe_pkg::PRICE_BITS-1:0] low_thr  = tsoe_pkg::LOW_RST;
  logic [tsoe_pkg::PRICE_BITS-1:0] high_thr = tsoe_pkg::HIGH_RST;
  logic [tsoe_pkg::BAND_W-1:0]     band_pct = tsoe_pkg::BAND_RST;
  logic [tsoe_pkg::MINH_W-1:0]     min_hist = tsoe_pkg::MINH_RST;
  logic [tsoe_pkg::OFFS_W-1:0]     offset   = tsoe_pkg::OFFS_RST;
  logic [tsoe_pkg::PRICE_BITS-1:0] tick_hist [tsoe_pkg::INST_CNT][WINDOW];
  int unsigned                     hist_fill [tsoe_pkg::INST_CNT] = '{default: 0};
  int unsigned                     hist_head [tsoe_pkg::INST_CNT] = '{default: 0};
  longint unsigned                 hist_sum  [tsoe_pkg::INST_CNT] = '{default: 0};
  logic [tsoe_pkg::CNT_W-1:0]      fire_count [3] = '{default: '0};

  order_t pending_orders [$];
  int     mismatches   = 0;
  int     quiet_cycles = 0;
  int     in_gap_pct   = 0;
  int     out_stall_pct = 0;
  int     stall_left   = 0;

  tick_signal_order_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(input int pct);
    if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 4);
  endfunction

  function automatic void check_field(input string field, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  function automatic order_t predict_order(input logic [tsoe_pkg::INST_W-1:0] inst,
                                           input logic [tsoe_pkg::PRICE_BITS-1:0] price);
    order_t                        res;
    int unsigned                   slot, n;
    longint unsigned               p, sum, lhs;
    logic                          sig_band, sig_dev, sig_rise, below_avg, buy, sell;
    logic [tsoe_pkg::PRICE_BITS:0] raised;
    res = '0;
    slot = hist_head[inst];
    if (hist_fill[inst] >= WINDOW) hist_sum[inst] -= tick_hist[inst][slot];
    else hist_fill[inst]++;
    tick_hist[inst][slot] = price;
    hist_sum[inst] += price;
    hist_head[inst] = (slot + 1) % WINDOW;
    n = hist_fill[inst];
    sum = hist_sum[inst];
    p = price;
    lhs = p * n * 100;

    sig_band = (price < low_thr) || (price > high_thr);
    sig_dev = 1'b0;
    if (n >= min_hist) begin
      sig_dev = lhs > sum * (100 + band_pct);
      if (band_pct < 100 && lhs < sum * (100 - band_pct)) sig_dev = 1'b1;
    end
    sig_rise = (n >= 3) &&
               (tick_hist[inst][(slot + WINDOW - 2) % WINDOW] <
                tick_hist[inst][(slot + WINDOW - 1) % WINDOW]) &&
               (tick_hist[inst][(slot + WINDOW - 1) % WINDOW] < price);
    below_avg = p * n < sum;

    if (sig_band && fire_count[0] != tsoe_pkg::CNT_MAX) fire_count[0]++;
    if (sig_dev && fire_count[1] != tsoe_pkg::CNT_MAX) fire_count[1]++;
    if (sig_rise && fire_count[2] != tsoe_pkg::CNT_MAX) fire_count[2]++;

    buy = sig_band || sig_rise || (sig_dev && below_avg);
    sell = sig_dev && !below_avg;
    raised = price + offset;
    if (buy) begin
      res.order_price = raised[tsoe_pkg::PRICE_BITS] ? tsoe_pkg::PRICE_MAX
                                                      : raised[tsoe_pkg::PRICE_BITS-1:0];
    end else if (sell) begin
      res.order_price = (price > offset) ? price - offset : '0;
    end
    res.order_valid = buy || sell;
    res.is_buy = buy;
    res.order_instrument = inst;
    res.band_hits = fire_count[0];
    res.dev_hits = fire_count[1];
    res.rise_hits = fire_count[2];
    return res;
  endfunction

  function automatic logic [tsoe_pkg::CFG_DW-1:0] reg_value(input int idx);
    case (idx)
      tsoe_pkg::REG_LOW:  return tsoe_pkg::CFG_DW'(low_thr);
      tsoe_pkg::REG_HIGH: return tsoe_pkg::CFG_DW'(high_thr);
      tsoe_pkg::REG_BAND: return tsoe_pkg::CFG_DW'(band_pct);
      tsoe_pkg::REG_MINH: return tsoe_pkg::CFG_DW'(min_hist);
      tsoe_pkg::REG_OFFS: return tsoe_pkg::CFG_DW'(offset);
      default:            return '0;
    endcase
  endfunction

  // result side: random back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left = pick_gap(100) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    order_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = order_t'(out_tdata);
      if (pending_orders.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("order with no tick pending: %h", out_tdata);
      end else begin
        want = pending_orders.pop_front();
        check_field("order_valid", want.order_valid, got.order_valid);
        check_field("is_buy", want.is_buy, got.is_buy);
        check_field("order_instrument", want.order_instrument, got.order_instrument);
        check_field("order_price", want.order_price, got.order_price);
        check_field("signal_one_count", want.band_hits, got.band_hits);
        check_field("signal_two_count", want.dev_hits, got.dev_hits);
        check_field("signal_three_count", want.rise_hits, got.rise_hits);
        check_field("padding", want.spare, got.spare);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_tick(input logic [tsoe_pkg::INST_W-1:0] inst,
                           input logic [tsoe_pkg::PRICE_BITS-1:0] price);
    int gap;
    gap = pick_gap(in_gap_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {price, inst};
    do @(posedge clk); while (!in_tready);
    pending_orders.insert(pending_orders.size(), predict_order(inst, price));
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_orders.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [tsoe_pkg::CFG_DW-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= tsoe_pkg::CFG_AW'(idx * 4);
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      tsoe_pkg::REG_LOW:  low_thr = data[tsoe_pkg::PRICE_BITS-1:0];
      tsoe_pkg::REG_HIGH: high_thr = data[tsoe_pkg::PRICE_BITS-1:0];
      tsoe_pkg::REG_BAND: band_pct = data[tsoe_pkg::BAND_W-1:0];
      tsoe_pkg::REG_MINH: min_hist = data[tsoe_pkg::MINH_W-1:0];
      tsoe_pkg::REG_OFFS: offset = data[tsoe_pkg::OFFS_W-1:0];
      default: ;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input int idx);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= tsoe_pkg::CFG_AW'(idx * 4);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field($sformatf("register %0d", idx), reg_value(idx), cfg_prdata);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_burst(output int count);
    logic [tsoe_pkg::INST_W-1:0] inst;
    int price, shape;
    inst = tsoe_pkg::INST_W'($urandom);
    count = $urandom_range(3, 12);
    shape = $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0: price = $urandom_range(0, 2000);
      1: price = int'(tsoe_pkg::PRICE_MAX) - int'($urandom_range(0, 2000));
      default: price = $urandom_range(9000, 21000);
    endcase
    for (int i = 0; i < count; i++) begin
      send_tick(inst, tsoe_pkg::PRICE_BITS'(price));
      case (shape)
        0: price += int'($urandom_range(1, 300));
        1: price += int'($urandom_range(0, 600)) - 300;
        2: price += (i == count - 2) ? int'($urandom_range(0, 6000)) - 3000 : 0;
        default: price -= int'($urandom_range(1, 300));
      endcase
      if (price < 0) price = 0;
      if (price > int'(tsoe_pkg::PRICE_MAX)) price = int'(tsoe_pkg::PRICE_MAX);
    end
  endtask

  task automatic test_register_access();
    for (int r = tsoe_pkg::REG_LOW; r <= tsoe_pkg::REG_OFFS; r++) check_reg(r);
    for (int slot = FIRST_SPARE_REG; slot <= LAST_REG_SLOT; slot++) write_reg(slot, $urandom);
    for (int r = tsoe_pkg::REG_LOW; r <= tsoe_pkg::REG_OFFS; r++) check_reg(r);
  endtask

  task automatic test_default_signals();
    send_tick(4'd0, 20'd15000);
    send_tick(4'd15, '0);
    send_tick(4'd14, tsoe_pkg::PRICE_MAX);
    send_tick(4'd1, 20'd15000);
    send_tick(4'd1, 20'd15100);
    send_tick(4'd1, 20'd15200);
    wait_for_results();
  endtask

  // sell clamped at zero, buy below the average, wide band never fires low
  task automatic test_deviation_and_offsets();
    write_reg(tsoe_pkg::REG_LOW, '0);
    write_reg(tsoe_pkg::REG_HIGH, tsoe_pkg::CFG_DW'(tsoe_pkg::PRICE_MAX));
    write_reg(tsoe_pkg::REG_BAND, '0);
    write_reg(tsoe_pkg::REG_MINH, '0);
    write_reg(tsoe_pkg::REG_OFFS, tsoe_pkg::CFG_DW'({tsoe_pkg::OFFS_W{1'b1}}));
    send_tick(4'd3, 20'd500);
    send_tick(4'd3, 20'd900);
    send_tick(4'd4, 20'd16000);
    send_tick(4'd4, 20'd16000);
    send_tick(4'd4, 20'd14000);
    wait_for_results();
    write_reg(tsoe_pkg::REG_BAND, 32'hFFFF_FF80 | 32'd100);
    write_reg(tsoe_pkg::REG_MINH, 32'd1);
    send_tick(4'd6, 20'd1000);
    send_tick(4'd6, '0);
    wait_for_results();
    for (int r = tsoe_pkg::REG_LOW; r <= tsoe_pkg::REG_OFFS; r++) check_reg(r);
  endtask

  task automatic test_config_extremes();
    write_reg(tsoe_pkg::REG_BAND, 32'h0000_007F);
    write_reg(tsoe_pkg::REG_MINH, 32'd11);
    send_tick(4'd4, 20'd30000);
    wait_for_results();
    write_reg(tsoe_pkg::REG_MINH, 32'hFFFF_FFFF);
    write_reg(tsoe_pkg::REG_LOW, 32'hFFFF_FFFF);
    write_reg(tsoe_pkg::REG_HIGH, '0);
    write_reg(tsoe_pkg::REG_OFFS, '0);
    send_tick(4'd5, 20'h80000);
    send_tick(4'd4, 20'd1);
    wait_for_results();
    for (int r = tsoe_pkg::REG_LOW; r <= tsoe_pkg::REG_OFFS; r++) check_reg(r);
  endtask

  task automatic test_random_ticks();
    int  sent, burst;
    bit  paused;
    paused = 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      if (phase == 0) begin
        write_reg(tsoe_pkg::REG_LOW, tsoe_pkg::CFG_DW'(tsoe_pkg::LOW_RST));
        write_reg(tsoe_pkg::REG_HIGH, tsoe_pkg::CFG_DW'(tsoe_pkg::HIGH_RST));
        write_reg(tsoe_pkg::REG_BAND, tsoe_pkg::CFG_DW'(tsoe_pkg::BAND_RST));
        write_reg(tsoe_pkg::REG_MINH, tsoe_pkg::CFG_DW'(tsoe_pkg::MINH_RST));
        write_reg(tsoe_pkg::REG_OFFS, tsoe_pkg::CFG_DW'(tsoe_pkg::OFFS_RST));
      end else if (phase == 1) begin
        write_reg(tsoe_pkg::REG_LOW, '0);
        write_reg(tsoe_pkg::REG_HIGH, tsoe_pkg::CFG_DW'(tsoe_pkg::PRICE_MAX));
        write_reg(tsoe_pkg::REG_BAND, '0);
        write_reg(tsoe_pkg::REG_MINH, 32'd1);
        write_reg(tsoe_pkg::REG_OFFS, 32'hFFFF_FFFF);
      end else begin
        case ($urandom_range(0, 5))
          0: write_reg(tsoe_pkg::REG_LOW, '0);
          1: write_reg(tsoe_pkg::REG_LOW, 32'hFFFF_FFFF);
          default: write_reg(tsoe_pkg::REG_LOW,
                             ($urandom << tsoe_pkg::PRICE_BITS) | $urandom_range(9000, 15000));
        endcase
        case ($urandom_range(0, 5))
          0: write_reg(tsoe_pkg::REG_HIGH, 32'hFFFF_FFFF);
          1: write_reg(tsoe_pkg::REG_HIGH, '0);
          default: write_reg(tsoe_pkg::REG_HIGH,
                             ($urandom << tsoe_pkg::PRICE_BITS) | $urandom_range(15000, 21000));
        endcase
        write_reg(tsoe_pkg::REG_BAND,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 10));
        write_reg(tsoe_pkg::REG_MINH,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 10));
        write_reg(tsoe_pkg::REG_OFFS, $urandom);
      end
      in_gap_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 50);
      out_stall_pct = (phase % 4 == 0) ? 0 : $urandom_range(10, 50);
      sent = 0;
      while (sent < PHASE_TICKS) begin
        if (phase == 2 && !paused && sent >= PHASE_TICKS / 2) begin
          wait_for_results();
          paused = 1'b1;
        end
        if ($urandom_range(0, 4) == 0) begin
          send_tick(tsoe_pkg::INST_W'($urandom), tsoe_pkg::PRICE_BITS'($urandom));
          sent++;
        end else begin
          send_burst(burst);
          sent += burst;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_default_signals();
    test_deviation_and_offsets();
    test_config_extremes();
    test_random_ticks();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
